FILE: design/ssp_pkg.sv
// Shared types and constants for the servo sweep pulse controller.
// Used by the top level and by the iterative divider; depends on nothing.
package ssp_pkg;

  // Width of the shared divider's dividend, divisor, quotient and remainder.
  localparam int DIV_W  = 32;
  localparam int DIV_CW = $clog2(DIV_W);

  // Fixed field widths.
  localparam int PULSE_W = 16;
  localparam int REQ_W   = 16;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_AW  = 3;

  // Command codes carried in the input tuser.
  localparam logic [1:0] OP_SET_ANGLE = 2'd0;
  localparam logic [1:0] OP_START     = 2'd1;
  localparam logic [1:0] OP_STEP      = 2'd2;
  localparam logic [1:0] OP_STOP      = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_ANGLE_LIMIT = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PULSE_MIN   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_PULSE_MAX   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SWEEP_LOW   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SWEEP_HIGH  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SWEEP_STEP  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_STEP_PERIOD = 3'd6;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/ssp_divider.sv
// Iterative restoring divider shared by the sequencer, one quotient bit per cycle.
// Depends on ssp_pkg for its width and the status struct.
module ssp_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ssp_pkg::DIV_W-1:0] dividend,
  input  logic [ssp_pkg::DIV_W-1:0] divisor,
  output ssp_pkg::div_stat_t        stat,
  output logic [ssp_pkg::DIV_W-1:0] quotient,
  output logic [ssp_pkg::DIV_W-1:0] remainder
);
  import ssp_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (busy_r) begin
      rem_nxt = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r + DIV_CW'(1);
      if (cnt_r == DIV_CW'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: design/servo_sweep_pulse_controller.sv
// Servo sweep pulse controller: commands in, pulse width words out.
// Depends on ssp_pkg and ssp_divider.
//
// Usage: the input channel carries one command word per handshake, with the
// command code in in_tuser and the requested angle and current millisecond
// time in in_tdata. Each command except a sweep step that is not yet due
// gives one result word on the output channel: the new pulse width, the
// angle after the command and the sweep direction. Registers are written
// through cfg_we/cfg_addr/cfg_wdata; the user must do so only while no command
// is in flight, which the block itself does not enforce. in_tready is high
// only while the sequencer is idle; one command is worked at a time. Set
// angle, start and stop take one multiply and one pass through the shared
// divider. A sweep step adds the elapsed-time division, then walks the steps
// in turn until the walk first turns at the high angle (bounded by twice the
// angle range), and two more divisions when it turns there with steps left,
// which fold the remaining count by the period. A finished result sits in the
// output register; the next command is still taken while it waits, and a
// later result holds the sequencer until the receiver takes the earlier one.
// Reset loads the register defaults, angle zero, direction up and step time
// zero; no result is pending afterwards.
module servo_sweep_pulse_controller #(
  parameter int ANGLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ssp_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [ssp_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // Fields from bit 0: angle_request[15:0], now_ms[31:0].
  input  logic [47:0]                   in_tdata,
  // Fields from bit 0: operation[1:0].
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // Fields from bit 0: pulse_width[15:0], angle_now[ANGLE_BITS-1:0], sweeping_up,
  // then zero fill.
  output logic [((ssp_pkg::PULSE_W + ANGLE_BITS + 1 + 7) / 8) * 8 - 1:0] out_tdata
);
  import ssp_pkg::*;

  localparam int B     = ANGLE_BITS;
  localparam int OUT_W = ((PULSE_W + ANGLE_BITS + 1 + 7) / 8) * 8;
  localparam int PROD_W = B + PULSE_W;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_DCNT = 11'b00000000010,
    S_WALK = 11'b00000000100,
    S_DK   = 11'b00000001000,
    S_DM   = 11'b00000010000,
    S_WMUL = 11'b00000100000,
    S_WFIN = 11'b00001000000,
    S_MUL  = 11'b00010000000,
    S_DPL  = 11'b00100000000,
    S_DP   = 11'b01000000000,
    S_EMIT = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration.
  logic [B-1:0]       lim_r, lo_r, hi_r, stp_r;
  logic [PULSE_W-1:0] pmin_r, pmax_r;
  logic [15:0]        per_r;

  // Servo state.
  logic [B-1:0]      cur_r, cur_nxt;
  logic              up_r, up_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;

  // Working registers.
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [TIME_W-1:0]  cnt_r, cnt_nxt;
  logic [B-1:0]       k_r, k_nxt;
  logic [B-1:0]       opa_r, opa_nxt;
  logic               down_r, down_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [PULSE_W-1:0] res_r, res_nxt;

  // Output register.
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [PULSE_W-1:0] out_pulse_r, out_pulse_nxt;
  logic [B-1:0]       out_angle_r, out_angle_nxt;
  logic               out_up_r, out_up_nxt;

  // Divider hookup.
  logic              div_start;
  logic [DIV_W-1:0]  div_dvd, div_dvs, div_quo, div_rem;
  div_stat_t         div_stat;

  // Derived configuration.
  logic [PULSE_W-1:0] span;
  logic [B-1:0]       div_lim, st_eff, dlen;
  logic [15:0]        per_eff;

  // Single step of the triangle walk.
  logic [B:0]   sum_up, lo_st;
  logic [B-1:0] walk_cur;
  logic         walk_up;
  logic         fold;

  logic [B:0]         kdvd;
  logic [B-1:0]       k_now;
  logic               c_lt;
  logic [DIV_W-1:0]   c_sub;
  logic [B-1:0]       wfin_cur;
  logic [PROD_W-1:0]  mul_out;
  logic [PULSE_W-1:0] mul_b;
  logic [REQ_W-1:0]   cand, lim_ext;
  logic [B-1:0]       clamped;
  logic               in_acc;

  assign span    = (pmax_r >= pmin_r) ? pmax_r - pmin_r : '0;
  assign div_lim = (lim_r != '0) ? lim_r : B'(1);
  assign st_eff  = (stp_r != '0) ? stp_r : B'(1);
  assign per_eff = (per_r != '0) ? per_r : 16'd1;
  assign dlen    = (hi_r > lo_r) ? hi_r - lo_r : '0;

  always_comb begin
    sum_up = {1'b0, cur_r} + {1'b0, st_eff};
    lo_st  = {1'b0, lo_r} + {1'b0, st_eff};
    if (up_r) begin
      if (sum_up >= {1'b0, hi_r}) begin
        walk_cur = hi_r;
        walk_up  = 1'b0;
      end else begin
        walk_cur = sum_up[B-1:0];
        walk_up  = 1'b1;
      end
    end else if ({1'b0, cur_r} <= lo_st) begin
      walk_cur = lo_r;
      walk_up  = 1'b1;
    end else begin
      walk_cur = cur_r - st_eff;
      walk_up  = 1'b0;
    end
  end

  // The count is folded by the triangle period the first time the walk turns
  // downward at the high angle.
  assign fold = !walk_up && (walk_cur == hi_r);

  // Ceiling of the sweep span over the step angle, for the half period.
  assign kdvd  = {1'b0, dlen} + {1'b0, st_eff} - (B+1)'(1);
  assign k_now = (dlen != '0) ? div_quo[B-1:0] : B'(1);

  assign c_lt  = div_rem < DIV_W'(k_r);
  assign c_sub = div_rem - DIV_W'(k_r);

  assign wfin_cur = down_r ? hi_r - prod_r[B-1:0] : lo_r + prod_r[B-1:0];

  // One shared multiplier: angle times span for the pulse, or steps times
  // step angle for the folded walk.
  assign mul_b   = (state_r == S_MUL) ? span : PULSE_W'(st_eff);
  assign mul_out = PROD_W'(opa_r) * PROD_W'(mul_b);

  always_comb begin
    case (state_r)
      S_IDLE:  cand = (in_tuser == OP_SET_ANGLE) ? in_tdata[REQ_W-1:0] : REQ_W'(lo_r);
      S_WALK:  cand = REQ_W'(walk_cur);
      S_WFIN:  cand = REQ_W'(wfin_cur);
      default: cand = REQ_W'(cur_r);
    endcase
  end

  assign lim_ext = REQ_W'(lim_r);
  assign clamped = (cand > lim_ext) ? lim_r : cand[B-1:0];

  assign in_tready = (state_r == S_IDLE) && !div_stat.busy;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    up_nxt         = up_r;
    last_nxt       = last_r;
    now_nxt        = now_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    opa_nxt        = opa_r;
    down_nxt       = down_r;
    prod_nxt       = prod_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r;
    out_pulse_nxt  = out_pulse_r;
    out_angle_nxt  = out_angle_r;
    out_up_nxt     = out_up_r;
    div_start      = 1'b0;
    div_dvd        = '0;
    div_dvs        = '0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          now_nxt = in_tdata[47:16];
          case (in_tuser)
            OP_STEP: begin
              div_start = 1'b1;
              div_dvd   = in_tdata[47:16] - last_r;
              div_dvs   = DIV_W'(per_eff);
              state_nxt = S_DCNT;
            end
            OP_START: begin
              up_nxt    = 1'b1;
              last_nxt  = in_tdata[47:16];
              cur_nxt   = clamped;
              opa_nxt   = clamped;
              state_nxt = S_MUL;
            end
            OP_STOP: begin
              up_nxt    = 1'b1;
              cur_nxt   = clamped;
              opa_nxt   = clamped;
              state_nxt = S_MUL;
            end
            default: begin
              cur_nxt   = clamped;
              opa_nxt   = clamped;
              state_nxt = S_MUL;
            end
          endcase
        end
      end
      S_DCNT: begin
        if (div_stat.done) begin
          if (div_quo == '0) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = div_quo;
            // Advancing by whole periods lands at the time minus the remainder.
            last_nxt  = now_r - div_rem;
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        cnt_nxt = cnt_r - TIME_W'(1);
        up_nxt  = walk_up;
        cur_nxt = walk_cur;
        if (cnt_r == TIME_W'(1)) begin
          cur_nxt   = clamped;
          opa_nxt   = clamped;
          state_nxt = S_MUL;
        end else if (fold) begin
          div_start = 1'b1;
          div_dvd   = DIV_W'(kdvd);
          div_dvs   = DIV_W'(st_eff);
          state_nxt = S_DK;
        end
      end
      S_DK: begin
        if (div_stat.done) begin
          k_nxt     = k_now;
          div_start = 1'b1;
          div_dvd   = cnt_r;
          div_dvs   = DIV_W'({k_now, 1'b0});
          state_nxt = S_DM;
        end
      end
      S_DM: begin
        if (div_stat.done) begin
          // Still on the way down from the high angle, or past the low turn.
          down_nxt  = c_lt;
          opa_nxt   = c_lt ? div_rem[B-1:0] : c_sub[B-1:0];
          state_nxt = S_WMUL;
        end
      end
      S_WMUL: begin
        prod_nxt  = mul_out;
        state_nxt = S_WFIN;
      end
      S_WFIN: begin
        up_nxt    = !down_r;
        cur_nxt   = clamped;
        opa_nxt   = clamped;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = mul_out;
        state_nxt = S_DPL;
      end
      S_DPL: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(prod_r);
        div_dvs   = DIV_W'(div_lim);
        state_nxt = S_DP;
      end
      S_DP: begin
        if (div_stat.done) begin
          res_nxt   = pmin_r + div_quo[PULSE_W-1:0];
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_pulse_nxt  = res_r;
          out_angle_nxt  = cur_r;
          out_up_nxt     = up_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      cur_r        <= '0;
      up_r         <= 1'b1;
      last_r       <= '0;
      lim_r        <= B'(180);
      pmin_r       <= 16'd500;
      pmax_r       <= 16'd2500;
      lo_r         <= '0;
      hi_r         <= B'(180);
      stp_r        <= B'(1);
      per_r        <= 16'd20;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      cur_r        <= cur_nxt;
      up_r         <= up_nxt;
      last_r       <= last_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_ANGLE_LIMIT: lim_r  <= cfg_wdata[B-1:0];
          REG_PULSE_MIN:   pmin_r <= cfg_wdata;
          REG_PULSE_MAX:   pmax_r <= cfg_wdata;
          REG_SWEEP_LOW:   lo_r   <= cfg_wdata[B-1:0];
          REG_SWEEP_HIGH:  hi_r   <= cfg_wdata[B-1:0];
          REG_SWEEP_STEP:  stp_r  <= cfg_wdata[B-1:0];
          REG_STEP_PERIOD: per_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
    now_r       <= now_nxt;
    cnt_r       <= cnt_nxt;
    k_r         <= k_nxt;
    opa_r       <= opa_nxt;
    down_r      <= down_nxt;
    prod_r      <= prod_nxt;
    res_r       <= res_nxt;
    out_pulse_r <= out_pulse_nxt;
    out_angle_r <= out_angle_nxt;
    out_up_r    <= out_up_nxt;
  end

  ssp_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({out_up_r, out_angle_r, out_pulse_r});

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for servo_sweep_pulse_controller: directed commands, then random
// sweeps under several register settings and idle patterns. Depends on ssp_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
  import ssp_pkg::*;

  localparam int ANGLE_W       = 10;
  localparam int CYCLE_LIMIT   = 20_000_000;
  // Worst step command: elapsed-time division, a walk of up to about twice the angle range
  // and the folding divisions, with room to spare.
  localparam int SETTLE_CYCLES = 5000;

  typedef struct packed {
    logic               up;
    logic [ANGLE_W-1:0] angle;
    logic [15:0]        pulse;
  } servo_word_t;

  typedef struct packed {
    int unsigned limit;
    int unsigned pmin;
    int unsigned pmax;
    int unsigned lo;
    int unsigned hi;
    int unsigned step;
    int unsigned period;
  } servo_cfg_t;

  typedef struct packed {
    int          cfg_sel;
    logic [1:0]  op;
    logic [15:0] req;
    logic [31:0] now;
    bit          typed;
    logic [15:0] pulse;
    logic [9:0]  angle;
    bit          up;
  } directed_row_t;

  // Register settings used by the directed rows: zero limit; maximum below minimum with zero
  // step angle and period; field extremes with low above high; high turning point above limit.
  localparam servo_cfg_t DIR_CFG[4] = '{
    '{0,    500,  2500,  0,    180,  1,    20},
    '{1023, 3000, 1000,  0,    1023, 0,    0},
    '{1023, 0,    65535, 1000, 10,   1023, 65535},
    '{100,  1000, 2000,  50,   900,  7,    3}
  };

  localparam directed_row_t DIRECTED[26] = '{
    '{-1, OP_SET_ANGLE, 16'd0,     32'd0,          1, 16'd500,   10'd0,    1'b1},
    '{-1, OP_SET_ANGLE, 16'd180,   32'd0,          1, 16'd2500,  10'd180,  1'b1},
    '{-1, OP_SET_ANGLE, 16'hFFFF,  32'hFFFFFFFF,   1, 16'd2500,  10'd180,  1'b1},
    '{-1, OP_SET_ANGLE, 16'd90,    32'd0,          1, 16'd1500,  10'd90,   1'b1},
    '{-1, OP_START,     16'hFFFF,  32'd1000,       1, 16'd500,   10'd0,    1'b1},
    '{-1, OP_STEP,      16'd0,     32'd1019,       0, 16'd0,     10'd0,    1'b0},
    '{-1, OP_STEP,      16'd0,     32'd1020,       1, 16'd511,   10'd1,    1'b1},
    '{-1, OP_STEP,      16'd0,     32'd4600,       1, 16'd2500,  10'd180,  1'b0},
    '{-1, OP_STEP,      16'd0,     32'd4640,       0, 16'd0,     10'd0,    1'b0},
    '{-1, OP_STEP,      16'd0,     32'd2004640,    0, 16'd0,     10'd0,    1'b0},
    '{-1, OP_STEP,      16'd0,     32'h00000010,   0, 16'd0,     10'd0,    1'b0},
    '{-1, OP_STOP,      16'h5A5A,  32'hFFFFFFFF,   1, 16'd500,   10'd0,    1'b1},
    '{-1, OP_START,     16'd0,     32'hFFFFFFF0,   1, 16'd500,   10'd0,    1'b1},
    '{-1, OP_STEP,      16'd0,     32'h00000004,   1, 16'd511,   10'd1,    1'b1},
    '{0,  OP_SET_ANGLE, 16'd500,   32'd0,          1, 16'd500,   10'd0,    1'b1},
    '{-1, OP_STEP,      16'd0,     32'd44,         1, 16'd500,   10'd0,    1'b1},
    '{1,  OP_STOP,      16'd0,     32'd0,          1, 16'd3000,  10'd0,    1'b1},
    '{-1, OP_SET_ANGLE, 16'd1023,  32'd0,          1, 16'd3000,  10'd1023, 1'b1},
    '{-1, OP_START,     16'd0,     32'd100,        1, 16'd3000,  10'd0,    1'b1},
    '{-1, OP_STEP,      16'd0,     32'd103,        1, 16'd3000,  10'd3,    1'b1},
    '{2,  OP_SET_ANGLE, 16'd1023,  32'd0,          1, 16'd65535, 10'd1023, 1'b1},
    '{-1, OP_START,     16'd0,     32'hFFFFFFFF,   0, 16'd0,     10'd0,    1'b0},
    '{-1, OP_STEP,      16'd0,     32'd65534,      0, 16'd0,     10'd0,    1'b0},
    '{3,  OP_START,     16'd0,     32'd5,          1, 16'd1500,  10'd50,   1'b1},
    '{-1, OP_STEP,      16'd0,     32'd605,        0, 16'd0,     10'd0,    1'b0},
    '{-1, OP_STEP,      16'd0,     32'd300605,     0, 16'd0,     10'd0,    1'b0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [47:0]         in_tdata = '0;
  logic [1:0]          in_tuser = OP_SET_ANGLE;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [31:0]         out_tdata;

  // Typed expectation travelling alongside the word on the input channel.
  bit                  typed_flag = 1'b0;
  servo_word_t         typed_word = '0;

  // Predictor state and register copy.
  servo_cfg_t          regs = '{180, 500, 2500, 0, 180, 1, 20};
  int unsigned         servo_angle = 0;
  bit                  sweep_up = 1'b1;
  logic [31:0]         last_tick_ms = '0;

  servo_word_t         pending_words[$];
  int unsigned         in_idle_pct = 0;
  int unsigned         out_stall_pct = 0;
  logic [31:0]         ms_clock = '0;
  int                  n_fail = 0;
  int                  n_checked = 0;
  int                  n_not_due = 0;
  int                  n_cmds = 0;
  int                  n_settings = 1;
  int                  cycle_count = 0;

  servo_sweep_pulse_controller #(.ANGLE_BITS(ANGLE_W)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // angle_request[15:0], now_ms[31:0]
    .in_tuser   (in_tuser),   // operation[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // pulse_width[15:0], angle_now[9:0], sweeping_up, zero fill
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamps the angle, stores it and maps it onto the pulse range.
  function automatic logic [15:0] angle_to_pulse(input int unsigned ang);
    int unsigned span;
    int unsigned divisor;
    span    = (regs.pmax >= regs.pmin) ? regs.pmax - regs.pmin : 0;
    divisor = (regs.limit != 0) ? regs.limit : 1;
    if (ang > regs.limit) ang = regs.limit;
    servo_angle = ang & 32'h3FF;
    return 16'(regs.pmin + (servo_angle * span) / divisor);
  endfunction

  // Walks the triangle; once it turns at the high angle the rest is folded by one period.
  function automatic int unsigned walk_triangle(input int unsigned count);
    int unsigned st;
    int unsigned tri_span;
    int unsigned period;
    int unsigned cur;
    bit          folded;
    st       = (regs.step != 0) ? regs.step : 1;
    tri_span = (regs.hi > regs.lo) ? regs.hi - regs.lo : 0;
    period   = 2 * ((tri_span != 0) ? (tri_span + st - 1) / st : 1);
    cur      = servo_angle;
    folded   = 1'b0;
    while (count > 0) begin
      if (sweep_up) begin
        if (cur + st >= regs.hi) begin
          cur = regs.hi;
          sweep_up = 1'b0;
        end else begin
          cur += st;
        end
      end else if (cur <= regs.lo + st) begin
        cur = regs.lo;
        sweep_up = 1'b1;
      end else begin
        cur -= st;
      end
      count--;
      if (!folded && !sweep_up && cur == regs.hi) begin
        count  = count % period;
        folded = 1'b1;
      end
    end
    return cur;
  endfunction

  // Returns 0 for a step that is not yet due; otherwise fills in the expected word.
  function automatic bit next_pulse_word(input logic [1:0] op, input logic [15:0] req,
                                         input logic [31:0] now, output servo_word_t w);
    int unsigned per;
    int unsigned elapsed;
    int unsigned count;
    w = '0;
    case (op)
      OP_SET_ANGLE: begin
        w.pulse = angle_to_pulse(req);
      end
      OP_START: begin
        sweep_up     = 1'b1;
        last_tick_ms = now;
        w.pulse      = angle_to_pulse(regs.lo);
      end
      OP_STEP: begin
        per     = (regs.period != 0) ? regs.period : 1;
        elapsed = now - last_tick_ms;
        count   = elapsed / per;
        if (count == 0) return 1'b0;
        last_tick_ms = last_tick_ms + count * per;
        w.pulse      = angle_to_pulse(walk_triangle(count));
      end
      default: begin
        sweep_up = 1'b1;
        w.pulse  = angle_to_pulse(regs.lo);
      end
    endcase
    w.angle = servo_angle[ANGLE_W-1:0];
    w.up    = sweep_up;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    servo_word_t got;
    servo_word_t want;
    servo_word_t pred;
    bit          has;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[26:0];
        if (pending_words.size() == 0) begin
          $error("result word %h arrived with nothing expected", out_tdata);
          n_fail++;
        end else begin
          want = pending_words.pop_front();
          n_checked++;
          if (got.pulse !== want.pulse) begin
            $error("pulse_width: expected %0d, got %0d", want.pulse, got.pulse);
            n_fail++;
          end
          if (got.angle !== want.angle) begin
            $error("angle_now: expected %0d, got %0d", want.angle, got.angle);
            n_fail++;
          end
          if (got.up !== want.up) begin
            $error("sweeping_up: expected %0d, got %0d", want.up, got.up);
            n_fail++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        has = next_pulse_word(in_tuser, in_tdata[15:0], in_tdata[47:16], pred);
        if (has) pending_words.push_back(typed_flag ? typed_word : pred);
        else n_not_due++;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= out_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run timed out with %0d result words outstanding.", pending_words.size());
      $display("** servo_sweep_pulse_controller: FAILED **");
      $finish;
    end
  end

  task automatic send_cmd(input logic [1:0] op, input logic [15:0] req, input logic [31:0] now,
                          input bit typed, input servo_word_t word);
    if (in_idle_pct != 0 && $urandom_range(99, 0) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < in_idle_pct);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= op;
    in_tdata   <= {now, req};
    typed_flag <= typed;
    typed_word <= word;
    do @(posedge clk); while (!in_tready);
    n_cmds++;
  endtask

  // Lets the block drain: every expected word back, then time for a step that gives none.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_AW-1:0] addr, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
  endtask

  task automatic load_regs(input servo_cfg_t c);
    put_reg(REG_ANGLE_LIMIT, c.limit);
    put_reg(REG_PULSE_MIN, c.pmin);
    put_reg(REG_PULSE_MAX, c.pmax);
    put_reg(REG_SWEEP_LOW, c.lo);
    put_reg(REG_SWEEP_HIGH, c.hi);
    put_reg(REG_SWEEP_STEP, c.step);
    put_reg(REG_STEP_PERIOD, c.period);
    cfg_we <= 1'b0;
    regs.limit  = c.limit & 32'h3FF;
    regs.pmin   = c.pmin & 32'hFFFF;
    regs.pmax   = c.pmax & 32'hFFFF;
    regs.lo     = c.lo & 32'h3FF;
    regs.hi     = c.hi & 32'h3FF;
    regs.step   = c.step & 32'h3FF;
    regs.period = c.period & 32'hFFFF;
    n_settings++;
  endtask

  // Uniform in range, with the ends themselves favored.
  function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(9, 0);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  task automatic random_config();
    servo_cfg_t  c;
    int unsigned tmp;
    c.limit = pick(1, 1023);
    c.pmin  = pick(0, 65535);
    c.pmax  = pick(0, 65535);
    if ($urandom_range(3, 0) != 0 && c.pmax < c.pmin) begin
      tmp    = c.pmin;
      c.pmin = c.pmax;
      c.pmax = tmp;
    end
    if ($urandom_range(5, 0) == 0) begin
      c.lo = $urandom_range(1023, 0);
      c.hi = $urandom_range(1023, 0);
    end else begin
      c.lo = $urandom_range(c.limit, 0);
      c.hi = $urandom_range(c.limit, c.lo);
    end
    c.step = ($urandom_range(2, 0) != 0) ? $urandom_range(16, 1) : pick(1, 1023);
    case ($urandom_range(3, 0))
      0:       c.period = $urandom_range(8, 1);
      1:       c.period = $urandom_range(100, 1);
      2:       c.period = $urandom_range(5000, 1);
      default: c.period = pick(1, 65535);
    endcase
    load_regs(c);
  endtask

  // A sweep: start, then mostly steps at or past their due time, with set-angle, restart,
  // stop, early steps and jumps of the time base mixed in.
  task automatic random_phase(input int n);
    int unsigned r;
    int unsigned per;
    logic [1:0]  op;
    logic [15:0] req;
    send_cmd(OP_START, 16'($urandom), ms_clock, 1'b0, '0);
    for (int i = 1; i < n; i++) begin
      r   = $urandom_range(99, 0);
      per = (regs.period != 0) ? regs.period : 1;
      req = 16'($urandom);
      op  = OP_STEP;
      if (r < 8) begin
        op = OP_SET_ANGLE;
        if (r < 5) req = 16'($urandom_range(regs.limit + 4, 0));
      end else if (r < 12) begin
        op = OP_START;
      end else if (r < 15) begin
        op = OP_STOP;
      end else if (r < 18) begin
        ms_clock = $urandom;
      end else if (r < 36) begin
        ms_clock += $urandom_range(per - 1, 0);
      end else if (r < 88) begin
        ms_clock += per * $urandom_range(4, 1) + $urandom_range(per - 1, 0);
      end else if (r < 97) begin
        ms_clock += per * $urandom_range(3000, 5);
      end else begin
        ms_clock += $urandom;
      end
      send_cmd(op, req, ms_clock, 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned in_pct[4];
    int unsigned out_pct[4];
    in_pct  = '{0, 73, 0, 21};
    out_pct = '{0, 0, 73, 21};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].cfg_sel >= 0) begin
        settle();
        load_regs(DIR_CFG[DIRECTED[i].cfg_sel]);
      end
      send_cmd(DIRECTED[i].op, DIRECTED[i].req, DIRECTED[i].now, DIRECTED[i].typed,
               '{up: DIRECTED[i].up, angle: DIRECTED[i].angle, pulse: DIRECTED[i].pulse});
    end

    for (int m = 0; m < 4; m++) begin
      for (int p = 0; p < 4; p++) begin
        settle();
        in_idle_pct   = in_pct[m];
        out_stall_pct = out_pct[m];
        random_config();
        random_phase(90);
      end
    end

    in_idle_pct   = 0;
    out_stall_pct = 0;
    settle();

    $display("Sent %0d commands over %0d register settings and four idle patterns.",
             n_cmds, n_settings);
    $display("Checked %0d result words; %0d sweep steps were not yet due.",
             n_checked, n_not_due);
    if (n_fail == 0) begin
      $display("** servo_sweep_pulse_controller: PASSED **");
    end else begin
      $display("** servo_sweep_pulse_controller: FAILED **");
    end
    $finish;
  end

endmodule
